// ----- sv/tam_pkg.sv -----
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types and constants for the three-axis moving-average filter.
// ----------------------------------------------------------------------------
package tam_pkg;

	localparam int SAMPLE_W = 17;
	localparam int AXES     = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ----- sv/tam_sample_if.sv -----
// ----------------------------------------------------------------------------
// tam_sample_if
// Valid/ready channel carrying one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
interface tam_sample_if;

	logic            valid;
	logic            ready;
	tam_pkg::sample_t sample_x;
	tam_pkg::sample_t sample_y;
	tam_pkg::sample_t sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);

endinterface

// ----- sv/tam_mean_if.sv -----
// ----------------------------------------------------------------------------
// tam_mean_if
// Valid/ready channel carrying one three-axis windowed mean.
// ----------------------------------------------------------------------------
interface tam_mean_if;

	logic            valid;
	logic            ready;
	tam_pkg::sample_t mean_x;
	tam_pkg::sample_t mean_y;
	tam_pkg::sample_t mean_z;

	modport source (output valid, output mean_x, output mean_y, output mean_z,
		input ready);
	modport sink (input valid, input mean_x, input mean_y, input mean_z,
		output ready);

endinterface

// ----- sv/three_axis_moving_average_top.sv -----
// From sample transfer to mean valid: one update/write, SW divider steps and one
// output load, SW = 17 + clog2(WINDOW); the load waits while the last mean is not taken.
// A new sample is accepted only back in idle, after the mean is loaded; the radix-2
// restoring divider has a shared step counter, and the three axes divide in parallel.
// Reset: sums, slot pointer and fill flag clear at once; unfilled ring slots read as
// zero through the fill flag, so the sample memory needs no clearing pass.
// ----------------------------------------------------------------------------
// three_axis_moving_average_top
// Running-sum moving average over three axes, ring held in one sync memory.
// ----------------------------------------------------------------------------
module three_axis_moving_average_top #(
	parameter int WINDOW = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	tam_sample_if.sink   samples,
	tam_mean_if.source   means
);

	localparam int SW    = tam_pkg::SAMPLE_W + $clog2(WINDOW);
	localparam int SLW   = $clog2(WINDOW);
	localparam int DVW   = $clog2(WINDOW + 1);
	localparam int CW    = $clog2(SW);
	localparam int WW    = tam_pkg::AXES * tam_pkg::SAMPLE_W;
	localparam int EXT_W = SW - tam_pkg::SAMPLE_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [SLW-1:0]         slot_q;
	logic                   full_q;
	logic [CW-1:0]          cnt_q;
	logic [DVW-1:0]         div_q;
	logic signed [SW-1:0]   total_q [tam_pkg::AXES];
	tam_pkg::sample_t       samp_q  [tam_pkg::AXES];
	logic [DVW-1:0]         rem_q   [tam_pkg::AXES];
	logic [SW-1:0]          quo_q   [tam_pkg::AXES];
	logic                   neg_q   [tam_pkg::AXES];
	tam_pkg::sample_t       mean_q  [tam_pkg::AXES];
	logic                   out_valid_q;

	logic [WW-1:0]          mem [WINDOW];
	logic [WW-1:0]          rd_q;
	logic [WW-1:0]          wr_data;
	logic                   mem_we;

	logic                   in_xfer;
	logic                   out_free;
	logic                   last_slot;
	logic                   full_n;
	logic [DVW-1:0]         divisor;
	logic signed [SW-1:0]   total_n [tam_pkg::AXES];
	logic [DVW-1:0]         rem_n   [tam_pkg::AXES];
	logic [SW-1:0]          quo_n   [tam_pkg::AXES];
	logic [SW-1:0]          quo_s   [tam_pkg::AXES];

	assign samples.ready = (state_q == S_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || means.ready;
	assign mem_we        = (state_q == S_READ);
	assign wr_data       = {samp_q[2], samp_q[1], samp_q[0]};

	assign last_slot = (slot_q == SLW'(WINDOW - 1));
	assign full_n    = full_q || last_slot;
	assign divisor   = full_n ? DVW'(WINDOW) : (DVW'(slot_q) + DVW'(1));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= wr_data;
		end
		rd_q <= mem[slot_q];
	end

	always_comb begin
		logic [tam_pkg::SAMPLE_W-1:0] old_raw;
		logic [DVW:0]                 shifted;
		logic [DVW:0]                 diff;
		for (int a = 0; a < tam_pkg::AXES; a++) begin
			old_raw = full_q ? rd_q[a*tam_pkg::SAMPLE_W +: tam_pkg::SAMPLE_W]
				: '0;
			total_n[a] = total_q[a]
				- $signed({{EXT_W{old_raw[tam_pkg::SAMPLE_W-1]}}, old_raw})
				+ $signed({{EXT_W{samp_q[a][tam_pkg::SAMPLE_W-1]}}, samp_q[a]});
			quo_s[a] = neg_q[a] ? (~quo_q[a] + SW'(1)) : quo_q[a];
			shifted  = {rem_q[a], quo_q[a][SW-1]};
			diff     = shifted - {1'b0, div_q};
			if (!diff[DVW]) begin
				rem_n[a] = diff[DVW-1:0];
				quo_n[a] = {quo_q[a][SW-2:0], 1'b1};
			end else begin
				rem_n[a] = shifted[DVW-1:0];
				quo_n[a] = {quo_q[a][SW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < tam_pkg::AXES; a++) begin
				total_q[a] <= '0;
			end
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (means.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					for (int a = 0; a < tam_pkg::AXES; a++) begin
						total_q[a] <= total_n[a];
					end
					slot_q  <= last_slot ? '0 : slot_q + SLW'(1);
					full_q  <= full_n;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SW - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			samp_q[0] <= samples.sample_x;
			samp_q[1] <= samples.sample_y;
			samp_q[2] <= samples.sample_z;
		end
		if (state_q == S_READ) begin
			div_q <= divisor;
			for (int a = 0; a < tam_pkg::AXES; a++) begin
				neg_q[a] <= total_n[a][SW-1];
				quo_q[a] <= total_n[a][SW-1] ? (~total_n[a] + SW'(1)) : total_n[a];
				rem_q[a] <= '0;
			end
		end else if (state_q == S_DIV) begin
			for (int a = 0; a < tam_pkg::AXES; a++) begin
				rem_q[a] <= rem_n[a];
				quo_q[a] <= quo_n[a];
			end
		end
		if (state_q == S_DONE && out_free) begin
			for (int a = 0; a < tam_pkg::AXES; a++) begin
				mean_q[a] <= quo_s[a][tam_pkg::SAMPLE_W-1:0];
			end
		end
	end

	assign means.valid  = out_valid_q;
	assign means.mean_x = mean_q[0];
	assign means.mean_y = mean_q[1];
	assign means.mean_z = mean_q[2];

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> divisor != '0)
		else $error("zero divisor loaded");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(full_q))
		else $error("fill flag dropped");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("mean presented outside completion");

	a_slot_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !full_q) |-> slot_q != '0)
		else $error("slot pointer inconsistent with fill flag");

endmodule
